// ===== hdl/cmh_pkg.sv =====
// Shared types and constants for the constant magnitude histogram.
package cmh_pkg;

    // Input opcodes
    localparam logic [2:0] OP_REC_INT   = 3'd0;
    localparam logic [2:0] OP_REC_FLOAT = 3'd1;
    localparam logic [2:0] OP_REC_OTHER = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;

    // Float classes, offset from the first float bin
    localparam logic [2:0] FC_ZERO  = 3'd0;
    localparam logic [2:0] FC_ONE   = 3'd1;
    localparam logic [2:0] FC_TWO   = 3'd2;
    localparam logic [2:0] FC_HALF  = 3'd3;
    localparam logic [2:0] FC_POW2  = 3'd4;
    localparam logic [2:0] FC_OTHER = 3'd5;

    // Bins past the integer bins: six float classes and one for other kinds
    localparam int EXTRA_BINS = 7;
    localparam int OTHER_OFS  = 6;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [10:0] EXP_ONE      = 11'h3FF;
    localparam logic [10:0] EXP_TWO      = 11'h400;
    localparam logic [10:0] EXP_HALF     = 11'h3FE;

    typedef enum logic [1:0] {
        K_NOP,
        K_INC,
        K_READ,
        K_CLEAR
    } kind_t;

    // Control of one beat as it moves down the pipe
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [5:0] bin;
        logic       in_range;
    } stage_ctl_t;

endpackage

// ===== hdl/cmh_if.sv =====
// Valid/ready channel interfaces for the histogram's input and result beats.
interface cmh_item_if;
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic signed [63:0] int_value;
    logic [63:0]       float_bits;
    logic [5:0]        read_index;

    modport source (output valid, opcode, int_value, float_bits, read_index, input ready);
    modport sink   (input valid, opcode, int_value, float_bits, read_index, output ready);
endinterface

interface cmh_result_if;
    logic        valid;
    logic        ready;
    logic [5:0]  bin;
    logic [31:0] count;

    modport source (output valid, bin, count, input ready);
    modport sink   (input valid, bin, count, output ready);
endinterface

// ===== hdl/constant_magnitude_histogram.sv =====
// Top level: counter bank in RAM with read-modify-write and write forwarding.
//
//   port    | dir | fields                                       | role
//   --------+-----+----------------------------------------------+---------------------
//   item    | in  | opcode, int_value, float_bits, read_index    | record/read/clear
//   result  | out | bin, count                                   | one beat per item
//
// Cycles: one beat per cycle sustained while the output register is taken, clear
//   included; a beat passes the first classify stage (loaded on the accepting
//   edge), then the second classify stage, the RAM read and the output reg.
// Reset: counters read as zero through per-bin valid bits, so no clearing pass.
//   A clear drops all valid bits at once.
// Stalls: a full output register that is not taken freezes the whole pipe;
//   item.ready drops in that same cycle.
module constant_magnitude_histogram #(
    parameter int INT_BINS   = 32,
    parameter int COUNT_BITS = 32
) (
    input logic           clk,
    input logic           rst_n,
    cmh_item_if.sink      item,
    cmh_result_if.source  result
);
    import cmh_pkg::*;

    localparam int NUM_BINS = INT_BINS + EXTRA_BINS;
    localparam int AW       = $clog2(NUM_BINS);

    // global advance: the pipe moves whenever the output register can take a beat
    logic go;

    stage_ctl_t    s2_ctl;
    logic [AW-1:0] s2_addr;

    // stage 3: RAM data arrives, counter is updated and written back
    stage_ctl_t    s3_ctl_reg;
    logic [AW-1:0] s3_addr_reg;

    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  we;

    // per-bin valid bits; a bin that is not valid reads as zero
    logic [NUM_BINS-1:0] vld_reg, vld_next;

    // last write, forwarded to cover the write that lands on the read edge
    logic                  lw_valid_reg, lw_valid_next;
    logic [AW-1:0]         lw_addr_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;
    logic                  lw_hit;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [5:0]  out_bin_reg, out_bin_next;
    logic [31:0] out_count_reg, out_count_next;

    assign go         = !out_valid_reg || result.ready;
    assign item.ready = go;

    cmh_classify #(
        .INT_BINS (INT_BINS),
        .AW       (AW)
    ) u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (go),
        .in_valid   (item.valid),
        .opcode     (item.opcode),
        .int_value  (item.int_value),
        .float_bits (item.float_bits),
        .read_index (item.read_index),
        .ctl        (s2_ctl),
        .addr       (s2_addr)
    );

    cmh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s3_addr_reg),
        .wdata (new_cnt),
        .re    (go),
        .raddr (s2_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else if (go)
        begin
            s3_ctl_reg <= s2_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s3_addr_reg <= s2_addr;
        end
    end

    // read-modify-write of the selected counter
    always_comb
    begin
        lw_hit  = lw_valid_reg && (lw_addr_reg == s3_addr_reg);
        if (lw_hit)
        begin
            old_cnt = lw_data_reg;
        end
        else if (vld_reg[s3_addr_reg])
        begin
            old_cnt = rdata;
        end
        else
        begin
            old_cnt = '0;
        end
        new_cnt = old_cnt + COUNT_BITS'(1);
        we      = s3_ctl_reg.valid && go && (s3_ctl_reg.kind == K_INC);
    end

    always_comb
    begin
        vld_next      = vld_reg;
        lw_valid_next = lw_valid_reg;
        if (s3_ctl_reg.valid && go)
        begin
            if (s3_ctl_reg.kind == K_CLEAR)
            begin
                vld_next      = '0;
                lw_valid_next = 1'b0;
            end
            else if (s3_ctl_reg.kind == K_INC)
            begin
                vld_next[s3_addr_reg] = 1'b1;
                lw_valid_next         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg      <= vld_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            lw_addr_reg <= s3_addr_reg;
            lw_data_reg <= new_cnt;
        end
    end

    // result beat
    always_comb
    begin
        out_valid_next = s3_ctl_reg.valid;
        out_bin_next   = s3_ctl_reg.bin;
        unique case (s3_ctl_reg.kind)
            K_INC:   out_count_next = 32'(new_cnt);
            K_READ:  out_count_next = s3_ctl_reg.in_range ? 32'(old_cnt) : '0;
            K_CLEAR: out_count_next = '0;
            K_NOP:   out_count_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_bin_reg   <= out_bin_next;
            out_count_reg <= out_count_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.bin   = out_bin_reg;
    assign result.count = out_count_reg;

endmodule

// ===== hdl/cmh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module cmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 39
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cmh_classify.sv =====
// Two-stage bin selection: magnitude and float class, then log2 and address.
module cmh_classify #(
    parameter int INT_BINS = 32,
    parameter int AW       = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0]         opcode,
    input  logic signed [63:0] int_value,
    input  logic [63:0]        float_bits,
    input  logic [5:0]         read_index,
    output cmh_pkg::stage_ctl_t ctl,
    output logic [AW-1:0]      addr
);
    import cmh_pkg::*;

    localparam int          NUM_BINS   = INT_BINS + EXTRA_BINS;
    localparam logic [6:0]  NUM_BINS7  = 7'(NUM_BINS);
    localparam logic [5:0]  TOP_INT    = 6'(INT_BINS - 1);
    localparam logic [AW-1:0] FLOAT_BASE = AW'(INT_BINS);
    localparam logic [AW-1:0] OTHER_ADDR = AW'(INT_BINS + OTHER_OFS);

    // stage 1
    logic        s1_valid_reg, s1_valid_next;
    logic [2:0]  s1_op_reg;
    logic [63:0] s1_mag_reg;
    logic [2:0]  s1_fcls_reg;
    logic [5:0]  s1_idx_reg;

    // stage 2
    stage_ctl_t    s2_ctl_reg, s2_ctl_next;
    logic [AW-1:0] s2_addr_reg, s2_addr_next;

    logic        f_sign;
    logic [10:0] f_exp;
    logic        f_mant_nz;
    logic [2:0]  fcls;
    logic [63:0] mag;

    logic [7:0]  byte_nz;
    logic [2:0]  hi_byte;
    logic [7:0]  sel_byte;
    logic [2:0]  lo_bit;
    logic [5:0]  lg;
    logic [5:0]  lg_clamp;

    // float class and magnitude
    always_comb
    begin
        f_sign    = float_bits[63];
        f_exp     = float_bits[62:52];
        f_mant_nz = |float_bits[51:0];
        mag       = int_value[63] ? (64'd0 - int_value) : int_value;
        if (f_exp == '0 && !f_mant_nz)
        begin
            fcls = FC_ZERO;
        end
        else if (f_exp == '0 || f_exp == EXP_ALL_ONES || f_mant_nz)
        begin
            fcls = FC_OTHER;
        end
        else if (!f_sign && f_exp == EXP_ONE)
        begin
            fcls = FC_ONE;
        end
        else if (!f_sign && f_exp == EXP_TWO)
        begin
            fcls = FC_TWO;
        end
        else if (!f_sign && f_exp == EXP_HALF)
        begin
            fcls = FC_HALF;
        end
        else
        begin
            fcls = FC_POW2;
        end
    end

    assign s1_valid_next = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_ctl_reg   <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_ctl_reg   <= s2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= opcode;
            s1_mag_reg  <= mag;
            s1_fcls_reg <= fcls;
            s1_idx_reg  <= read_index;
            s2_addr_reg <= s2_addr_next;
        end
    end

    // floor(log2) as top byte, then top bit in that byte
    always_comb
    begin
        hi_byte = '0;
        lo_bit  = '0;
        for (int i = 0; i < 8; i++)
        begin
            byte_nz[i] = |s1_mag_reg[8*i +: 8];
        end
        for (int i = 0; i < 8; i++)
        begin
            if (byte_nz[i])
            begin
                hi_byte = 3'(i);
            end
        end
        sel_byte = s1_mag_reg[8*hi_byte +: 8];
        for (int i = 0; i < 8; i++)
        begin
            if (sel_byte[i])
            begin
                lo_bit = 3'(i);
            end
        end
        lg       = {hi_byte, lo_bit};
        lg_clamp = (lg > TOP_INT) ? TOP_INT : lg;
    end

    always_comb
    begin
        s2_ctl_next.valid    = s1_valid_reg;
        s2_ctl_next.kind     = K_NOP;
        s2_ctl_next.bin      = '0;
        s2_ctl_next.in_range = 1'b0;
        s2_addr_next         = '0;
        unique case (s1_op_reg)
            OP_REC_INT:
            begin
                s2_ctl_next.kind = K_INC;
                s2_addr_next     = AW'(lg_clamp);
            end
            OP_REC_FLOAT:
            begin
                s2_ctl_next.kind = K_INC;
                s2_addr_next     = FLOAT_BASE + AW'(s1_fcls_reg);
            end
            OP_REC_OTHER:
            begin
                s2_ctl_next.kind = K_INC;
                s2_addr_next     = OTHER_ADDR;
            end
            OP_READ:
            begin
                s2_ctl_next.kind     = K_READ;
                s2_ctl_next.in_range = ({1'b0, s1_idx_reg} < NUM_BINS7);
                s2_addr_next         = AW'(s1_idx_reg);
            end
            OP_CLEAR:
            begin
                s2_ctl_next.kind = K_CLEAR;
            end
            default:
            begin
                s2_ctl_next.kind = K_NOP;
            end
        endcase
        if (s2_ctl_next.kind == K_INC)
        begin
            s2_ctl_next.bin = 6'(s2_addr_next);
        end
        else if (s2_ctl_next.kind == K_READ)
        begin
            s2_ctl_next.bin = s1_idx_reg;
        end
    end

    assign ctl  = s2_ctl_reg;
    assign addr = s2_addr_reg;

endmodule

// ===== bench/tb_constant_magnitude_histogram.sv =====
// Testbench for the constant magnitude histogram: directed and random beats, scoreboarded.
`timescale 1ns / 100ps

module tb_constant_magnitude_histogram;
    import cmh_pkg::*;

    localparam int INT_BINS   = 32;
    localparam int COUNT_BITS = 32;
    localparam int NUM_BINS   = INT_BINS + EXTRA_BINS;
    localparam int OTHER_BIN  = INT_BINS + OTHER_OFS;

    // Opcodes the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_BEATS = 500;
    localparam int QUIET_TAIL   = 60;   // last random beats run with no idling
    localparam int HOLD_AT      = 150;  // start of the long result hold-off
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_AT     = 300;  // sender waits for an empty scoreboard here

    typedef struct packed {
        logic [5:0]  bin;
        logic [31:0] count;
    } bin_count_t;

    // Shadow counter bank plus the queue of result beats still owed by the block.
    class histogram_scoreboard;
        logic [COUNT_BITS-1:0] tally [NUM_BINS];
        bin_count_t            owed [$];
        int                    errors;

        function new();
            foreach (tally[i])
                tally[i] = '0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return owed.size();
        endfunction

        // floor(log2 |v|), with 0 and 1 both giving 0
        function int mag_log2(input logic [63:0] raw);
            logic [63:0] mag;
            int          lg;
            mag = raw[63] ? -raw : raw;
            lg = 0;
            for (int i = 0; i < 64; i++)
                if (mag[i])
                    lg = i;
            return lg;
        endfunction

        function logic [2:0] float_class(input logic [63:0] bits);
            logic        sgn;
            logic [10:0] ex;
            logic [51:0] mt;
            sgn = bits[63];
            ex  = bits[62:52];
            mt  = bits[51:0];
            if (ex == '0 && mt == '0)
                return FC_ZERO;
            if (ex == '0 || ex == EXP_ALL_ONES || mt != '0)
                return FC_OTHER;
            if (!sgn && ex == EXP_ONE)
                return FC_ONE;
            if (!sgn && ex == EXP_TWO)
                return FC_TWO;
            if (!sgn && ex == EXP_HALF)
                return FC_HALF;
            return FC_POW2;
        endfunction

        function logic [31:0] bump(input int b);
            tally[b] = tally[b] + 1'b1;
            return tally[b][31:0];
        endfunction

        function void note_item(input logic [2:0] op, input logic [63:0] iv,
                                input logic [63:0] fb, input logic [5:0] ri);
            bin_count_t want;
            int         b;
            want = '0;
            case (op)
                OP_REC_INT:
                begin
                    b = mag_log2(iv);
                    if (b > INT_BINS - 1)
                        b = INT_BINS - 1;
                    want.bin   = 6'(b);
                    want.count = bump(b);
                end
                OP_REC_FLOAT:
                begin
                    b = INT_BINS + int'(float_class(fb));
                    want.bin   = 6'(b);
                    want.count = bump(b);
                end
                OP_REC_OTHER:
                begin
                    want.bin   = 6'(OTHER_BIN);
                    want.count = bump(OTHER_BIN);
                end
                OP_READ:
                begin
                    want.bin = ri;
                    if (ri < NUM_BINS)
                        want.count = tally[ri][31:0];
                end
                OP_CLEAR:
                begin
                    foreach (tally[i])
                        tally[i] = '0;
                end
                default:
                    ;
            endcase
            owed.push_back(want);
        endfunction

        task check_result(input logic [5:0] bin, input logic [31:0] count);
            bin_count_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected result beat bin=%0d count=%0d", bin, count));
                return;
            end
            want = owed.pop_front();
            if (bin !== want.bin)
                report($sformatf("bin: want %0d, got %0d", want.bin, bin));
            if (count !== want.count)
                report($sformatf("count of bin %0d: want %0d, got %0d",
                                 want.bin, want.count, count));
        endtask
    endclass

    logic clk;
    logic rst_n;

    cmh_item_if   item_bus ();
    cmh_result_if result_bus ();

    constant_magnitude_histogram #(
        .INT_BINS   (INT_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    histogram_scoreboard sb;

    // Shared between the sender and the result-side process
    bit idling_on;
    int hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run of 524 beats.
    initial
    begin
        #2_000_000;
        $display("constant_magnitude_histogram: mismatch");
        $finish;
    end

    //--------------------------------------------------------------------
    // Sender side. Inputs move on the falling edge; a beat counts at the
    // rising edge where valid and ready are both high.
    //--------------------------------------------------------------------
    task automatic send_item(input logic [2:0] op, input logic [63:0] iv,
                             input logic [63:0] fb, input logic [5:0] ri);
        @(negedge clk);
        item_bus.valid      = 1'b1;
        item_bus.opcode     = op;
        item_bus.int_value  = iv;
        item_bus.float_bits = fb;
        item_bus.read_index = ri;
        do
            @(posedge clk);
        while (!item_bus.ready);
        sb.note_item(op, iv, fb, ri);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        item_bus.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Magnitudes spread over all 64 octaves, either sign, plus the odd raw pattern.
    function automatic logic [63:0] pick_int();
        logic [63:0] mag;
        int          k;
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'd0;
            default:
            begin
                k   = $urandom_range(0, 63);
                mag = ({$urandom, $urandom} | 64'h8000_0000_0000_0000) >> (63 - k);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    // Biased toward the float classes that have bins of their own.
    function automatic logic [63:0] pick_float();
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] mt;
        sgn = 1'($urandom_range(0, 1));
        ex  = 11'($urandom_range(1, 11'h7FE));
        mt  = 52'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: mt = '0;
            2:
            begin
                sgn = 1'b0;
                mt  = '0;
                case ($urandom_range(0, 2))
                    0: ex = EXP_ONE;
                    1: ex = EXP_TWO;
                    default: ex = EXP_HALF;
                endcase
            end
            3:
            begin
                ex = '0;
                mt = '0;
            end
            4: ex = $urandom_range(0, 1) ? 11'd0 : EXP_ALL_ONES;
            default: ;
        endcase
        return {sgn, ex, mt};
    endfunction

    // Edge values for every defined opcode, two spare ones, and each corner of the classification.
    task automatic run_directed();
        send_item(OP_REC_INT, 64'd0, '0, '0);                       // zero -> bin 0
        send_item(OP_REC_INT, -64'sd1, '0, '0);
        send_item(OP_REC_INT, 64'd3, '0, '0);
        send_item(OP_REC_INT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);     // clamps to top int bin
        send_item(OP_REC_INT, 64'h8000_0000_0000_0000, '0, '0);     // most negative
        send_item(OP_REC_INT, 64'h0000_0001_0000_0000, '0, '0);
        send_item(OP_REC_FLOAT, '0, 64'd0, '0);                     // +0.0
        send_item(OP_REC_FLOAT, '0, {1'b1, 11'd0, 52'd0}, '0);      // -0.0
        send_item(OP_REC_FLOAT, '0, {1'b0, EXP_ONE, 52'd0}, '0);
        send_item(OP_REC_FLOAT, '0, {1'b0, EXP_TWO, 52'd0}, '0);
        send_item(OP_REC_FLOAT, '0, {1'b0, EXP_HALF, 52'd0}, '0);
        send_item(OP_REC_FLOAT, '0, {1'b1, EXP_ONE, 52'd0}, '0);    // -1.0: plain pow2
        send_item(OP_REC_FLOAT, '0, {1'b0, EXP_ONE, 52'h8_0000_0000_0000}, '0);
        send_item(OP_REC_FLOAT, '0, 64'd1, '0);                     // subnormal
        send_item(OP_REC_FLOAT, '0, {1'b0, EXP_ALL_ONES, 52'd0}, '0);
        send_item(OP_REC_FLOAT, '0, {1'b1, EXP_ALL_ONES, 52'h8_0000_0000_0000}, '0);
        send_item(OP_REC_OTHER, '0, '0, '0);
        send_item(OP_READ, '0, '0, 6'(INT_BINS - 1));
        send_item(OP_READ, '0, '0, 6'(OTHER_BIN));
        send_item(OP_READ, '0, '0, '1);                             // past the bank
        send_item(OP_SPARE_LO, {$urandom, $urandom}, {$urandom, $urandom}, 6'd7);
        send_item(OP_SPARE_HI, '0, '0, 6'd3);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_READ, '0, '0, 6'(INT_BINS + int'(FC_OTHER)));  // cleared bin
    endtask

    task automatic run_random();
        logic [2:0] op;
        int         sel;
        bit         gaps;
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            // Idle in stretches of 128 beats out of every 192, none in the tail.
            idling_on = ((i / 64) % 3 != 2) && (i < RANDOM_BEATS - QUIET_TAIL);
            gaps = idling_on && !(i >= HOLD_AT && i < HOLD_AT + 30);

            if (i == HOLD_AT)
                hold_off_cycles = HOLD_CYCLES;   // pipe backs up into item.ready
            if (i == DRAIN_AT)
            begin
                pause_sender(1);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (gaps && $urandom_range(0, 7) == 0)
                pause_sender($urandom_range(1, 17));

            sel = $urandom_range(0, 99);
            if (sel < 35)
                op = OP_REC_INT;
            else if (sel < 60)
                op = OP_REC_FLOAT;
            else if (sel < 68)
                op = OP_REC_OTHER;
            else if (sel < 94)
                op = OP_READ;
            else if (sel < 96)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

            send_item(op, pick_int(), pick_float(),
                      ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, NUM_BINS - 1))
                                                  : 6'($urandom_range(0, 63)));
        end
    endtask

    initial
    begin
        sb = new();
        idling_on           = 1'b0;
        hold_off_cycles     = 0;
        item_bus.valid      = 1'b0;
        item_bus.opcode     = OP_REC_INT;
        item_bus.int_value  = '0;
        item_bus.float_bits = '0;
        item_bus.read_index = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();

        // Let every owed beat arrive, then give stray beats a chance to show up.
        pause_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (sb.errors == 0)
            $display("constant_magnitude_histogram: match");
        else
            $display("constant_magnitude_histogram: mismatch");
        $finish;
    end

    //--------------------------------------------------------------------
    // Result side: ready changes on the falling edge. The long hold-off
    // is counted down here, cycle by cycle; random stalls come in bursts.
    //--------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                result_bus.ready = 1'b0;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                result_bus.ready = 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                result_bus.ready = 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
                result_bus.ready = 1'b1;
        end
    end

    // Result monitor: every accepted beat goes against the oldest expectation.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                sb.check_result(result_bus.bin, result_bus.count);
        end
    end

endmodule
